// File: design/event_pixel_frequency_detector_top_macros.svh
// assertion helpers for the frequency detector
`ifndef EVENT_PIXEL_FREQUENCY_DETECTOR_TOP_MACROS_SVH
`define EVENT_PIXEL_FREQUENCY_DETECTOR_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define EPFD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");

// next-cycle implication checked outside reset
`define EPFD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");

`endif

// File: design/epfd_pkg.sv
package epfd_pkg;
  localparam int WIDTH_DEF = 256;
  localparam int HEIGHT_DEF = 256;
  localparam int LIST_DEPTH_DEF = 1024;
  localparam int TS_W = 48;
  localparam int CNT_W = 11;
  localparam int MIN_PERIOD_US = 1000;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_SWEEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] CFG_MIN = 2'd0;
  localparam logic [1:0] CFG_MAX = 2'd1;
  localparam logic [1:0] CFG_REQ = 2'd2;
  localparam logic [1:0] CFG_EXP = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        polarity;
    logic [47:0] timestamp;
    logic [9:0]  list_index;
  } in_word_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [10:0] valid_count;
    logic [7:0]  entry_x;
    logic [7:0]  entry_y;
    logic [10:0] removed_count;
    logic        list_full;
  } out_word_t;
endpackage

// File: design/event_pixel_frequency_detector_top.sv
// channel | direction | handshake              | word
// cmd     | in        | start & !busy          | in_word_t
// result  | out       | done strobe, 1 cycle   | out_word_t
// cfg     | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
// event: pixel read, decide and write back, then done; read: list read, then done; a no-op or
// an out-of-range event goes straight to done; the next start is taken in the done cycle
// an event that pulls a pixel from mid-list also moves the last entry into the freed slot
// a sweep drops expired entries, filling each mid-list gap with the last entry
// after reset a clearing pass writes every pixel entry, one a cycle, while busy is high;
// config writes are taken at all times outside reset; done lasts one cycle, no stall
`include "event_pixel_frequency_detector_top_macros.svh"
module event_pixel_frequency_detector_top #(
  parameter int WIDTH = epfd_pkg::WIDTH_DEF,
  parameter int HEIGHT = epfd_pkg::HEIGHT_DEF,
  parameter int LIST_DEPTH = epfd_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  epfd_pkg::in_word_t  cmd,
  output logic               done,
  output epfd_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import epfd_pkg::*;

  localparam int NPIX = WIDTH * HEIGHT;
  localparam int PA_W = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int LA_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LC_W = $clog2(LIST_DEPTH + 1);
  localparam int SLOT_W = LA_W + 1;
  localparam int PE_W = TS_W + 8 + SLOT_W;

  // pixel entry: last time, match count, in-list bit, slot
  typedef struct packed {
    logic [TS_W-1:0] last;
    logic [7:0]      mcnt;
    logic            inl;
    logic [LA_W-1:0] slot;
  } pix_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EV_RD, S_MV_RD, S_MV_WB, S_RD_RD,
    S_SW_LR, S_SW_PR, S_SW_PD, S_SW_MV, S_SW_MW, S_DONE
  } state_t;

  state_t state;

  logic [PE_W-1:0] pmem [NPIX];
  logic [15:0]     lmem [LIST_DEPTH];

  logic            p_we;
  logic [PA_W-1:0] p_waddr, p_raddr;
  pix_t            p_wdata, p_rdata;
  logic            l_we;
  logic [LA_W-1:0] l_waddr, l_raddr;
  logic [15:0]     l_wdata, l_rdata;

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pix_t'(pmem[p_raddr]);
    if (l_we) lmem[l_waddr] <= l_wdata;
    l_rdata <= lmem[l_raddr];
  end

  logic [23:0] min_p, max_p, exp_us;
  logic [7:0]  req_m;
  logic [LC_W-1:0] total;
  in_word_t    cur;
  logic [PA_W-1:0] paddr, clr_addr, mv_pix;
  logic [LA_W-1:0] sw_i, mv_slot;
  logic [CNT_W-1:0] removed;
  logic pv, full;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  function automatic logic [PA_W-1:0] pix_of(logic [15:0] e);
    logic [31:0] p;
    p = 32'(e[15:8]) * 32'(WIDTH) + 32'(e[7:0]);
    return p[PA_W-1:0];
  endfunction

  logic [PA_W-1:0] in_pix;
  logic in_range;
  logic [31:0] in_pix_w;
  assign in_pix_w = 32'(cmd.y) * 32'(WIDTH) + 32'(cmd.x);
  assign in_pix = in_pix_w[PA_W-1:0];
  assign in_range = (32'(cmd.x) < 32'(WIDTH)) && (32'(cmd.y) < 32'(HEIGHT));

  // event decision from registered pixel read
  logic [TS_W-1:0] d;
  logic per_ok, in_win;
  logic [8:0] c_inc;
  logic qual;
  assign d = cur.timestamp - p_rdata.last;
  assign per_ok = (cur.timestamp >= p_rdata.last) && (d >= TS_W'(MIN_PERIOD_US));
  assign in_win = (d >= TS_W'(min_p)) && (d <= TS_W'(max_p));
  assign c_inc = {1'b0, p_rdata.mcnt} + 9'd1;
  assign qual = c_inc >= {1'b0, req_m};

  logic ev_hit, ev_add, ev_full, ev_drop;
  assign ev_hit = cur.polarity && per_ok && in_win && qual && !p_rdata.inl;
  assign ev_add = ev_hit && (32'(total) < 32'(LIST_DEPTH));
  assign ev_full = ev_hit && !ev_add;
  assign ev_drop = cur.polarity && per_ok && !in_win && p_rdata.inl;

  logic [TS_W-1:0] age;
  logic stale;
  assign age = cur.timestamp - p_rdata.last;
  assign stale = (cur.timestamp > p_rdata.last) && (age > TS_W'(exp_us));

  logic [LA_W-1:0] last_slot;
  assign last_slot = LA_W'(total - LC_W'(1));

  always_comb begin
    p_raddr = paddr;
    l_raddr = sw_i;
    p_we = 1'b0; p_waddr = paddr; p_wdata = '0;
    l_we = 1'b0; l_waddr = mv_slot; l_wdata = l_rdata;
    case (state)
      S_CLEAR: begin
        p_we = 1'b1; p_waddr = clr_addr;
      end
      S_IDLE: begin
        p_raddr = in_pix;
        l_raddr = LA_W'(cmd.list_index);
      end
      S_EV_RD: begin
        l_raddr = last_slot;
        if (cur.polarity) begin
          p_we = 1'b1;
          p_wdata = p_rdata;
          p_wdata.last = cur.timestamp;
          if (per_ok) begin
            if (in_win) begin
              p_wdata.mcnt = qual ? req_m : c_inc[7:0];
              if (ev_add) begin
                p_wdata.inl = 1'b1;
                p_wdata.slot = LA_W'(total);
                l_we = 1'b1; l_waddr = LA_W'(total);
                l_wdata = {cur.y, cur.x};
              end
            end else begin
              p_wdata.mcnt = '0;
              p_wdata.inl = 1'b0;
              p_wdata.slot = '0;
            end
          end
        end
      end
      // last entry is on l_rdata: copy it into the freed slot
      S_MV_RD: begin
        p_raddr = pix_of(l_rdata);
        l_we = 1'b1;
      end
      S_MV_WB: begin
        p_we = 1'b1; p_waddr = mv_pix;
        p_wdata = p_rdata; p_wdata.slot = mv_slot;
      end
      S_SW_LR: l_raddr = sw_i;
      S_SW_PR: p_raddr = pix_of(l_rdata);
      S_SW_PD: begin
        l_raddr = last_slot;
        if (stale) begin
          p_we = 1'b1; p_waddr = paddr; p_wdata = '0;
        end
      end
      S_SW_MV: begin
        p_raddr = pix_of(l_rdata);
        l_we = 1'b1;
      end
      S_SW_MW: begin
        p_we = 1'b1; p_waddr = mv_pix;
        p_wdata = p_rdata; p_wdata.slot = mv_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_DONE);
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      total <= '0;
      min_p <= 24'd1818; max_p <= 24'd2222; req_m <= 8'd5; exp_us <= 24'd6000;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MIN: min_p <= cfg_data;
          CFG_MAX: max_p <= cfg_data;
          CFG_REQ: req_m <= cfg_data[7:0];
          CFG_EXP: exp_us <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PA_W'(1);
          if (32'(clr_addr) == 32'(NPIX - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cur <= cmd; paddr <= in_pix;
          pv <= 1'b0; full <= 1'b0; removed <= '0; sw_i <= '0;
          result <= '0;
          case (cmd.req_type)
            REQ_EVENT: state <= in_range ? S_EV_RD : S_DONE;
            REQ_SWEEP: state <= (total == '0) ? S_DONE : S_SW_LR;
            REQ_READ:  state <= S_RD_RD;
            default:   state <= S_DONE;
          endcase
        end
        S_EV_RD: begin
          full <= ev_full;
          if (ev_add) begin
            total <= total + LC_W'(1);
            pv <= 1'b1;
            state <= S_DONE;
          end else if (ev_drop) begin
            total <= total - LC_W'(1);
            mv_slot <= p_rdata.slot;
            pv <= 1'b0;
            // swap the last entry into the freed slot
            state <= (p_rdata.slot != last_slot) ? S_MV_RD : S_DONE;
          end else begin
            pv <= p_rdata.inl;
            state <= S_DONE;
          end
        end
        S_MV_RD: begin
          mv_pix <= pix_of(l_rdata);
          state <= S_MV_WB;
        end
        S_MV_WB: state <= S_DONE;
        S_RD_RD: begin
          if (32'(cur.list_index) < 32'(total)) begin
            result.entry_x <= l_rdata[7:0];
            result.entry_y <= l_rdata[15:8];
          end
          state <= S_DONE;
        end
        S_SW_LR: state <= S_SW_PR;
        S_SW_PR: begin
          paddr <= pix_of(l_rdata);
          state <= S_SW_PD;
        end
        S_SW_PD: begin
          if (stale) begin
            removed <= removed + CNT_W'(1);
            total <= total - LC_W'(1);
            mv_slot <= sw_i;
            if (sw_i != last_slot) state <= S_SW_MV;
            else state <= S_DONE;
          end else if (32'(sw_i) + 1 >= 32'(total)) begin
            state <= S_DONE;
          end else begin
            sw_i <= sw_i + LA_W'(1);
            state <= S_SW_LR;
          end
        end
        S_SW_MV: begin
          mv_pix <= pix_of(l_rdata);
          state <= S_SW_MW;
        end
        S_SW_MW: begin
          // moved entry now sits in the freed slot, examine it next
          state <= S_SW_LR;
        end
        S_DONE: begin
          result.pixel_valid <= pv;
          result.valid_count <= CNT_W'(total);
          result.removed_count <= removed;
          result.list_full <= full;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EPFD_ASSERT_NXT(a_done_one, done, !done)
  `EPFD_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(total) <= 32'(LIST_DEPTH))
  `EPFD_ASSERT_IMP(a_busy_done, done, !busy)
  `EPFD_ASSERT_IMP(a_clear_busy, state == S_CLEAR, busy)
endmodule
